>>> rtl/sample_accumulation_buffer_resolve_top_macros.svh
// Assertion macros shared by the accumulation buffer RTL.
`ifndef SAMPLE_ACCUMULATION_BUFFER_RESOLVE_TOP_MACROS_SVH
`define SAMPLE_ACCUMULATION_BUFFER_RESOLVE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("accumulation buffer check failed");
// Check a property on every clock edge, reset included.
`define SAB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("accumulation buffer check failed");
`else
`define SAB_ASSERT(lbl, prop)
`define SAB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/sab_pkg.sv
// Types, constants and helpers of the accumulation buffer.
package sab_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 32;
  localparam int WORD_W   = 4 * SUM_W;
  localparam int CFG_W    = 9;
  localparam int COORD_W  = 8;
  localparam int CALC_W   = 18;
  localparam int RES_W    = 16;
  localparam int IN_DATA_W  = 2 * COORD_W + 4 * SAMPLE_W;
  localparam int OUT_DATA_W = 3 * RES_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);
  localparam logic [RES_W-1:0] CLAMP_Q16    = RES_W'(65470);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_SET     = 2'd1,
    OP_ADD     = 2'd2,
    OP_RESOLVE = 2'd3
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Saturating add of a sample to a 32-bit sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SAMPLE_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

>>> rtl/sab_ram.sv
// Generic single-port synchronous RAM with registered read.
module sab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

>>> rtl/sample_accumulation_buffer_resolve_top.sv
// Channel  | Dir | Handshake          | Payload
// in       | in  | in_tvalid/tready   | tuser: operation; tdata: column, row, r, g, b, weight
// out      | out | out_tvalid/tready  | tuser: zero_weight; tdata: red, green, blue
// cfg      | in  | cfg_valid/ready    | cfg_index, cfg_data
// Resolve runs 32 divide steps, then 16 square root steps, all three colours in
// parallel lanes. Clear writes width*height store entries (at most the store depth),
// one store entry per cycle through the single RAM port.
// After reset a clearing pass over all MAX_COLUMNS*MAX_ROWS entries runs before the
// first request is taken; configuration writes are taken at any time.
// A waiting result is held in the output register while the next request runs.
`include "sample_accumulation_buffer_resolve_top_macros.svh"
module sample_accumulation_buffer_resolve_top #(
  parameter int MAX_COLUMNS = sab_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = sab_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // column[7:0], row[15:8], red[31:16], green[47:32], blue[63:48], weight[79:64]
  input  logic [sab_pkg::IN_DATA_W-1:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // red[15:0], green[31:16], blue[47:32]
  output logic [sab_pkg::OUT_DATA_W-1:0] out_tdata,
  // zero_weight[0]
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [sab_pkg::CFG_W-1:0]     cfg_data
);
  import sab_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = CNT_W > CALC_W ? CNT_W : CALC_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_FETCH, ST_DIV, ST_SQRT, ST_RESULT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      width_r, width_nxt, height_r, height_nxt;
  op_t                   op_r, op_nxt;
  logic [COORD_W-1:0]    col_r, col_nxt, row_r, row_nxt;
  logic [SAMPLE_W-1:0]   smp_r [4];
  logic [SAMPLE_W-1:0]   smp_nxt [4];
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [CNT_W-1:0]      clr_idx_r, clr_idx_nxt, clr_end_r, clr_end_nxt;
  logic [SUM_W-1:0]      wsum_r, wsum_nxt;
  logic [SUM_W-1:0]      rem_r [3];
  logic [SUM_W-1:0]      rem_nxt [3];
  logic [SUM_W-1:0]      q_r [3];
  logic [SUM_W-1:0]      q_nxt [3];
  logic [RES_W-1:0]      root_r [3];
  logic [RES_W-1:0]      root_nxt [3];
  logic [RES_W+1:0]      srem_r [3];
  logic [RES_W+1:0]      srem_nxt [3];
  logic [2:0]            big_r, big_nxt;
  logic                  zw_r, zw_nxt;
  logic [4:0]            step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic [CALC_W-1:0]     addr_full, wh;
  logic [CMP_W-1:0]      addr_cmp, wh_cmp;
  logic                  in_store;
  logic [RES_W-1:0]      res [3];

  sab_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Pixel address and clear length from the latched request
  assign addr_full = CALC_W'(row_r) * CALC_W'(width_r) + CALC_W'(col_r);
  assign addr_cmp  = CMP_W'(addr_full);
  assign in_store  = addr_cmp < CMP_W'(DEPTH);
  assign wh        = CALC_W'(width_r) * CALC_W'(height_r);
  assign wh_cmp    = CMP_W'(wh);

  // Clamp each lane result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = (big_r[i] || root_r[i] > CLAMP_Q16) ? CLAMP_Q16 : root_r[i];
    end
  end

  // Memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_idx_r[ADDR_W-1:0];
      end
      ST_DECODE: begin
        ram_addr = addr_cmp[ADDR_W-1:0];
        if (in_store && op_r == OP_SET) begin
          ram_we    = 1'b1;
          ram_wdata = {SUM_W'(smp_r[3]), SUM_W'(smp_r[2]), SUM_W'(smp_r[1]),
                       SUM_W'(smp_r[0])};
        end else if (in_store && (op_r == OP_ADD || op_r == OP_RESOLVE)) begin
          ram_re = 1'b1;
        end
      end
      ST_FETCH: begin
        if (op_r == OP_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = {sat_add(ram_rdata[4*SUM_W-1:3*SUM_W], smp_r[3]),
                       sat_add(ram_rdata[3*SUM_W-1:2*SUM_W], smp_r[2]),
                       sat_add(ram_rdata[2*SUM_W-1:SUM_W], smp_r[1]),
                       sat_add(ram_rdata[SUM_W-1:0], smp_r[0])};
        end
      end
      default: ;
    endcase
  end

  // Next state of the sequencer and its datapath
  always_comb begin
    logic [SUM_W:0]   rem2;
    logic             ge;
    logic [RES_W+3:0] rem_t, trial;
    rem2          = '0;
    ge            = 1'b0;
    rem_t         = '0;
    trial         = '0;
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    op_nxt        = op_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    smp_nxt       = smp_r;
    addr_nxt      = addr_r;
    clr_idx_nxt   = clr_idx_r;
    clr_end_nxt   = clr_end_r;
    wsum_nxt      = wsum_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    big_nxt       = big_r;
    zw_nxt        = zw_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    // Configuration writes
    if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        width_nxt = cfg_data;
      end else begin
        height_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + CNT_W'(1);
        if (clr_idx_r + CNT_W'(1) == clr_end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_t'(in_tuser);
          col_nxt    = in_tdata[7:0];
          row_nxt    = in_tdata[15:8];
          smp_nxt[0] = in_tdata[31:16];
          smp_nxt[1] = in_tdata[47:32];
          smp_nxt[2] = in_tdata[63:48];
          smp_nxt[3] = in_tdata[79:64];
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        addr_nxt = addr_cmp[ADDR_W-1:0];
        case (op_r)
          OP_CLEAR: begin
            clr_idx_nxt = '0;
            clr_end_nxt = (wh_cmp > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(wh_cmp);
            state_nxt   = (wh == '0) ? ST_IDLE : ST_CLEAR;
          end
          OP_RESOLVE: begin
            if (in_store) begin
              state_nxt = ST_FETCH;
            end else begin
              zw_nxt    = 1'b1;
              state_nxt = ST_RESULT;
            end
          end
          OP_ADD:  state_nxt = in_store ? ST_FETCH : ST_IDLE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_FETCH: begin
        if (op_r == OP_RESOLVE) begin
          // Load the lanes; a sum not below the weight saturates the result
          wsum_nxt = ram_rdata[4*SUM_W-1:3*SUM_W];
          zw_nxt   = (ram_rdata[4*SUM_W-1:3*SUM_W] == '0);
          step_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            rem_nxt[i]  = ram_rdata[i*SUM_W +: SUM_W];
            big_nxt[i]  = ram_rdata[i*SUM_W +: SUM_W] >= ram_rdata[4*SUM_W-1:3*SUM_W];
            q_nxt[i]    = '0;
            root_nxt[i] = '0;
            srem_nxt[i] = '0;
          end
          state_nxt = (ram_rdata[4*SUM_W-1:3*SUM_W] == '0) ? ST_RESULT : ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        // One restoring divide step per lane
        for (int i = 0; i < 3; i++) begin
          rem2       = {rem_r[i], 1'b0};
          ge         = rem2 >= {1'b0, wsum_r};
          rem_nxt[i] = ge ? SUM_W'(rem2 - {1'b0, wsum_r}) : rem2[SUM_W-1:0];
          q_nxt[i]   = {q_r[i][SUM_W-2:0], ge};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // One restoring square root step per lane, two radicand bits a step
        for (int i = 0; i < 3; i++) begin
          rem_t       = {srem_r[i], q_r[i][SUM_W-1:SUM_W-2]};
          trial       = {2'b00, root_r[i], 2'b01};
          ge          = rem_t >= trial;
          srem_nxt[i] = ge ? (RES_W+2)'(rem_t - trial) : rem_t[RES_W+1:0];
          root_nxt[i] = {root_r[i][RES_W-2:0], ge};
          q_nxt[i]    = {q_r[i][SUM_W-3:0], 2'b00};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd15) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // Hand over when the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = zw_r;
          out_data_nxt  = zw_r ? '0 : {res[2], res[1], res[0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      clr_idx_r   <= '0;
      clr_end_r   <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_end_r   <= clr_end_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
    op_r       <= op_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    smp_r      <= smp_nxt;
    addr_r     <= addr_nxt;
    wsum_r     <= wsum_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    root_r     <= root_nxt;
    srem_r     <= srem_nxt;
    big_r      <= big_nxt;
    zw_r       <= zw_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  `SAB_ASSERT(a_clear_in_range, (state_r == ST_CLEAR) |-> (clr_idx_r < clr_end_r))
  `SAB_ASSERT(a_no_write_in_math, (state_r == ST_DIV || state_r == ST_SQRT) |-> !ram_we)
  `SAB_ASSERT(a_zero_weight_black, (out_valid_r && out_user_r) |-> (out_data_r == '0))
  `SAB_ASSERT(a_clamped, out_valid_r |-> (out_data_r[15:0] <= CLAMP_Q16 &&
    out_data_r[31:16] <= CLAMP_Q16 && out_data_r[47:32] <= CLAMP_Q16))
endmodule

>>> tb/sv/tb_sample_accumulation_buffer_resolve_top.sv
// Self-checking testbench for the accumulation buffer: random requests, predicted resolves.
module tb_sample_accumulation_buffer_resolve_top;
  import sab_pkg::*;

  localparam int STORE_DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam int DRAIN_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 80;

  // One expected resolve
  typedef struct {
    logic [RES_W-1:0] red;
    logic [RES_W-1:0] green;
    logic [RES_W-1:0] blue;
    logic             zero_weight;
  } resolve_t;

  // Four sums of one pixel
  typedef struct {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] weight;
  } pixel_t;

  // Mirror of the pixel store and the resolves still owed by the block
  class resolve_scoreboard;
    pixel_t            pixels[int unsigned];
    resolve_t          pending_resolves[$];
    logic [CFG_W-1:0]  image_width = WIDTH_RESET;
    logic [CFG_W-1:0]  image_height = HEIGHT_RESET;
    int                failures = 0;

    function void write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_WIDTH) image_width = value;
      else image_height = value;
    endfunction

    // floor(sqrt(sum * 2^32 / weight)), clamped to 0.999
    function logic [RES_W-1:0] gamma_root(logic [SUM_W-1:0] sum, logic [SUM_W-1:0] wt);
      logic [63:0] ratio;
      logic [63:0] root;
      logic [63:0] trial;
      ratio = {sum, 32'd0} / {32'd0, wt};
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= ratio) root = trial;
      end
      if (root > CLAMP_Q16) return CLAMP_Q16;
      return root[RES_W-1:0];
    endfunction

    function logic [SUM_W-1:0] saturate(logic [SUM_W-1:0] a, logic [SAMPLE_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // Apply one accepted request to the mirror
    function void note_request(op_t op, logic [7:0] col, logic [7:0] row,
                               logic [15:0] r, logic [15:0] g, logic [15:0] b,
                               logic [15:0] w);
      int unsigned addr;
      int unsigned count;
      int unsigned doomed[$];
      pixel_t px;
      resolve_t res;
      addr = row * image_width + col;
      case (op)
        OP_CLEAR: begin
          count = image_width * image_height;
          if (count > STORE_DEPTH) count = STORE_DEPTH;
          foreach (pixels[k]) if (k < count) doomed.push_back(k);
          foreach (doomed[i]) pixels.delete(doomed[i]);
        end
        OP_SET: begin
          if (addr < STORE_DEPTH) pixels[addr] = '{r, g, b, w};
        end
        OP_ADD: begin
          if (addr < STORE_DEPTH) begin
            px = pixels.exists(addr) ? pixels[addr] : pixel_t'{0, 0, 0, 0};
            px.red = saturate(px.red, r);
            px.green = saturate(px.green, g);
            px.blue = saturate(px.blue, b);
            px.weight = saturate(px.weight, w);
            pixels[addr] = px;
          end
        end
        default: begin
          px = (addr < STORE_DEPTH && pixels.exists(addr)) ? pixels[addr]
                                                           : pixel_t'{0, 0, 0, 0};
          if (px.weight == 0) res = '{0, 0, 0, 1'b1};
          else res = '{gamma_root(px.red, px.weight), gamma_root(px.green, px.weight),
                       gamma_root(px.blue, px.weight), 1'b0};
          pending_resolves.push_back(res);
        end
      endcase
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_result(logic [OUT_DATA_W-1:0] data, logic zw);
      resolve_t exp_res;
      if (pending_resolves.size() == 0) begin
        $error("unexpected result: data %h zero_weight %b", data, zw);
        failures++;
        return;
      end
      exp_res = pending_resolves.pop_front();
      if (data[15:0] !== exp_res.red) begin
        $error("resolved_red: expected %0d, actual %0d", exp_res.red, data[15:0]);
        failures++;
      end
      if (data[31:16] !== exp_res.green) begin
        $error("resolved_green: expected %0d, actual %0d", exp_res.green, data[31:16]);
        failures++;
      end
      if (data[47:32] !== exp_res.blue) begin
        $error("resolved_blue: expected %0d, actual %0d", exp_res.blue, data[47:32]);
        failures++;
      end
      if (zw !== exp_res.zero_weight) begin
        $error("zero_weight: expected %b, actual %b", exp_res.zero_weight, zw);
        failures++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [CFG_W-1:0]      cfg_data = '0;

  resolve_scoreboard board = new();
  bit calm = 1'b0;

  sample_accumulation_buffer_resolve_top uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result side at random, except in calm stretches
  always @(negedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 12);

  // Check every delivered result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
  end

  task automatic send_request(op_t op, logic [7:0] col, logic [7:0] row, logic [15:0] r,
                              logic [15:0] g, logic [15:0] b, logic [15:0] w);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {w, b, g, r, row, col};
    do @(posedge clk); while (!in_tready);
    board.note_request(op, col, row, r, g, b, w);
    @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until every predicted resolve is out, then let the pipe drain
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (board.pending_resolves.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_coord();
    return ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  // Random requests concentrated on a few pixels; clears only when cheap
  task automatic run_phase(int items, int first_item);
    int unsigned pick;
    op_t op;
    for (int i = 0; i < items; i++) begin
      calm = (first_item + i >= 300) && (first_item + i < 420);
      pick = $urandom_range(0, 99);
      if (pick < 4 && board.image_width * board.image_height <= 4096) op = OP_CLEAR;
      else if (pick < 25) op = OP_SET;
      else if (pick < 62) op = OP_ADD;
      else op = OP_RESOLVE;
      send_request(op, pick_coord(), pick_coord(), pick_sample(), pick_sample(),
                   pick_sample(), pick_sample());
    end
    calm = 1'b0;
    send_request(OP_RESOLVE, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    wait_drained();
  endtask

  initial begin
    int widths[8] = '{1, 511, 0, 7, 16, 256, 3, 256};
    int heights[8] = '{1, 511, 3, 5, 16, 1, 511, 256};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero weight, clamp, small ratios, full clear
    send_request(OP_RESOLVE, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_SET, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_RESOLVE, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_SET, 8'd3, 8'd2, 16'd0, 16'd1, 16'h4000, 16'h1000);
    send_request(OP_RESOLVE, 8'd3, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_ADD, 8'd3, 8'd2, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF);
    send_request(OP_RESOLVE, 8'd3, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_SET, 8'd1, 8'd0, 16'h1234, 16'h5678, 16'h9ABC, 16'd0);
    send_request(OP_RESOLVE, 8'd1, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_ADD, 8'd0, 8'd0, 16'h0001, 16'h0010, 16'h0100, 16'h1000);
    send_request(OP_ADD, 8'd0, 8'd0, 16'h8000, 16'h0800, 16'h0080, 16'h0008);
    send_request(OP_RESOLVE, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_CLEAR, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_RESOLVE, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(OP_RESOLVE, 8'd3, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
    wait_drained();

    // Random phases over several sizes; out-of-store rows show up at width 511
    for (int p = 0; p < 8; p++) begin
      write_register(REG_WIDTH, CFG_W'(widths[p]));
      write_register(REG_HEIGHT, CFG_W'(heights[p]));
      if (p == 1) begin
        send_request(OP_SET, 8'd255, 8'd255, 16'h00FF, 16'h0F0F, 16'hF0F0, 16'h0100);
        send_request(OP_RESOLVE, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(OP_CLEAR, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      end
      run_phase(ITEMS_PER_PHASE, p * ITEMS_PER_PHASE);
    end

    if (board.failures == 0 && board.pending_resolves.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(3_000_000 * 20);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
